// ----- sv/mlps_pkg.sv -----
// Shared types, codes and defaults for the multi-level priority store.
package mlps_pkg;

    localparam int LEVELS_DEF      = 5;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    // Levels shown in the empty mask
    localparam int MASK_LEVELS = 5;

    localparam int ACTION_W = 2;
    localparam int LEVEL_W  = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } t_lvl_ctl;

endpackage

// ----- sv/mlps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mlps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mlps_level.sv -----
// One priority level: entry count, head and tail registers, entry RAM.
module mlps_level
    import mlps_pkg::*;
#(
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    localparam int CW = $clog2(LEVEL_DEPTH + 1),
    localparam int AW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lvl_ctl              i_ctl,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic [CW-1:0]         o_cnt,
    output logic [CW-1:0]         o_cnt_nxt,
    output logic [DATA_WIDTH-1:0] o_head_nxt,
    output logic [DATA_WIDTH-1:0] o_tail_nxt
);

    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         n_cnt;
    logic [DATA_WIDTH-1:0] r_head;
    logic [DATA_WIDTH-1:0] n_head;
    logic [DATA_WIDTH-1:0] r_tail;
    logic [DATA_WIDTH-1:0] n_tail;
    logic [DATA_WIDTH-1:0] below;
    logic [CW:0]           rd_idx;

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.push) begin
            n_cnt  = r_cnt + CW'(1);
            n_tail = i_value;
            if (r_cnt == '0) begin
                n_head = i_value;
            end
        end else if (i_ctl.pop) begin
            n_cnt  = r_cnt - CW'(1);
            n_tail = below;
        end
    end

    // Prefetch the entry under the tail for the count of the next cycle
    assign rd_idx = {1'b0, n_cnt} - (CW + 1)'(2);

    mlps_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (LEVEL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (below)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_cnt      = r_cnt;
    assign o_cnt_nxt  = n_cnt;
    assign o_head_nxt = n_head;
    assign o_tail_nxt = n_tail;

endmodule

// ----- sv/mlps_select.sv -----
// Head and tail priority select, empty mask and total count over all levels.
module mlps_select
    import mlps_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    localparam int CW = $clog2(LEVEL_DEPTH + 1),
    localparam int SW = $clog2(LEVELS * LEVEL_DEPTH + 1)
) (
    input  logic [CW-1:0]         i_cnt  [LEVELS],
    input  logic [DATA_WIDTH-1:0] i_head [LEVELS],
    input  logic [DATA_WIDTH-1:0] i_tail [LEVELS],
    output logic [VALUE_W-1:0]    o_head_value,
    output logic                  o_head_valid,
    output logic [VALUE_W-1:0]    o_tail_value,
    output logic                  o_tail_valid,
    output logic [MASK_LEVELS-1:0] o_empty_mask,
    output logic [TOTAL_W-1:0]    o_total_count
);

    logic [DATA_WIDTH-1:0] head_d;
    logic [DATA_WIDTH-1:0] tail_d;
    logic                  any;
    logic [SW-1:0]         sum;
    logic [63:0]           head_ext;
    logic [63:0]           tail_ext;

    always_comb begin
        any    = 1'b0;
        head_d = '0;
        tail_d = '0;
        sum    = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (i_cnt[i] != '0) begin
                any    = 1'b1;
                head_d = i_head[i];
            end
        end
        for (int i = 0; i < LEVELS; i++) begin
            if (i_cnt[i] != '0) begin
                tail_d = i_tail[i];
            end
            sum = sum + SW'(i_cnt[i]);
        end
    end

    for (genvar g = 0; g < MASK_LEVELS; g++) begin : g_mask
        if (g < LEVELS) begin : g_on
            assign o_empty_mask[g] = (i_cnt[g] == '0);
        end else begin : g_off
            assign o_empty_mask[g] = 1'b0;
        end
    end

    assign head_ext      = 64'(signed'(head_d));
    assign tail_ext      = 64'(signed'(tail_d));
    assign o_head_value  = head_ext[VALUE_W-1:0];
    assign o_tail_value  = tail_ext[VALUE_W-1:0];
    assign o_head_valid  = any;
    assign o_tail_valid  = any;
    assign o_total_count = TOTAL_W'(sum);

endmodule

// ----- sv/multi_level_priority_store.sv -----
// Top level of the multi-level priority store.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | action[1:0] level[4:2] value[36:5], zero pad to 40
//  m_axis  | out | status[1:0] head_value[33:2] head_valid[34] tail_value[66:35]
//          |     | tail_valid[67] empty_mask[72:68] total_count[79:73]
//
// One transaction per cycle sustained while m_axis_tready holds; each passes the input
// register and then the result register, with the level count/head/tail registers updated in one pass.
// Reset clears the level counts at once; entry RAMs need no clearing pass.
// A stalled result holds the output register; the input register then holds
// one more transaction and s_axis_tready drops.
module multi_level_priority_store
    import mlps_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // action, level, value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status, head_value, head_valid,
                                                   // tail_value, tail_valid,
                                                   // empty_mask, total_count
);

    localparam int CW = $clog2(LEVEL_DEPTH + 1);

    logic                  r_in_v;
    logic [ACTION_W-1:0]   r_act;
    logic [LEVEL_W-1:0]    r_lvl;
    logic [VALUE_W-1:0]    r_val;
    logic                  r_out_v;
    logic [OUT_TDATA_W-1:0] r_out;

    logic                  fire;
    logic                  is_push;
    logic                  is_pop;
    logic [LEVELS-1:0]     sel;
    logic [CW-1:0]         sel_cnt;
    logic [STATUS_W-1:0]   status;
    logic [63:0]           val64;
    logic [DATA_WIDTH-1:0] wdata;

    logic [CW-1:0]         cnt      [LEVELS];
    logic [CW-1:0]         cnt_nxt  [LEVELS];
    logic [DATA_WIDTH-1:0] head_nxt [LEVELS];
    logic [DATA_WIDTH-1:0] tail_nxt [LEVELS];
    t_lvl_ctl              ctl      [LEVELS];

    logic [VALUE_W-1:0]     head_value;
    logic                   head_valid;
    logic [VALUE_W-1:0]     tail_value;
    logic                   tail_valid;
    logic [MASK_LEVELS-1:0] empty_mask;
    logic [TOTAL_W-1:0]     total_count;

    assign fire          = r_in_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_in_v || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_act <= s_axis_tdata[1:0];
            r_lvl <= s_axis_tdata[4:2];
            r_val <= s_axis_tdata[36:5];
        end
    end

    assign is_push = (r_act == ACT_PUSH);
    assign is_pop  = (r_act == ACT_POP);
    assign val64   = {32'b0, r_val};
    assign wdata   = val64[DATA_WIDTH-1:0];

    always_comb begin
        sel_cnt = '0;
        for (int i = 0; i < LEVELS; i++) begin
            sel[i] = (32'(r_lvl) == i + 1);
            if (sel[i]) begin
                sel_cnt = sel_cnt | cnt[i];
            end
        end
    end

    always_comb begin
        if (!(is_push || is_pop)) begin
            status = ST_OK;
        end else if (sel == '0) begin
            status = ST_BAD;
        end else if (is_push && sel_cnt == CW'(LEVEL_DEPTH)) begin
            status = ST_FULL;
        end else if (is_pop && sel_cnt == '0) begin
            status = ST_EMPTY;
        end else begin
            status = ST_OK;
        end
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        assign ctl[g].push = fire && is_push && sel[g] && (status == ST_OK);
        assign ctl[g].pop  = fire && is_pop && sel[g] && (status == ST_OK);

        mlps_level #(
            .LEVEL_DEPTH (LEVEL_DEPTH),
            .DATA_WIDTH  (DATA_WIDTH)
        ) u_level (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl[g]),
            .i_value    (wdata),
            .o_cnt      (cnt[g]),
            .o_cnt_nxt  (cnt_nxt[g]),
            .o_head_nxt (head_nxt[g]),
            .o_tail_nxt (tail_nxt[g])
        );
    end

    mlps_select #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_select (
        .i_cnt         (cnt_nxt),
        .i_head        (head_nxt),
        .i_tail        (tail_nxt),
        .o_head_value  (head_value),
        .o_head_valid  (head_valid),
        .o_tail_value  (tail_value),
        .o_tail_valid  (tail_valid),
        .o_empty_mask  (empty_mask),
        .o_total_count (total_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (fire) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= {total_count, empty_mask, tail_valid, tail_value,
                      head_valid, head_value, status};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

endmodule

// ----- sv/mlps_checker.sv -----
// Port-level checker for the multi-level priority store, bound to the top level.
module mlps_checker
    import mlps_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without an output stall");

    a_valid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[34] == m_axis_tdata[67])
        else $error("head and tail valid disagree");

    a_empty_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[34] |->
            m_axis_tdata[79:73] == '0 && m_axis_tdata[72:68] == '1 &&
            m_axis_tdata[33:2] == '0 && m_axis_tdata[66:35] == '0)
        else $error("empty store reports entries");

endmodule

bind multi_level_priority_store mlps_checker u_mlps_checker (.*);
